// ===== hdl/bfr_pkg.sv =====
package bfr_pkg;

    // frame overhead: start, length, type and check bytes
    localparam logic [7:0] OVERHEAD = 8'd4;

    // default largest data count of one frame
    localparam int MAX_DATA_DEF = 64;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_TYPE  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LEN_ERR = 2'd1,
        ST_SUM_ERR = 2'd2
    } t_status;

    // one result item
    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [1:0] frame_status;
    } t_result;

endpackage

// ===== hdl/bfr_ifs.sv =====
// receive byte channel
interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface bfr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [1:0] frame_status;

    modport source (output valid, output result_kind, output data_byte,
                    output frame_type, output frame_length, output frame_status,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input frame_type, input frame_length, input frame_status,
                    output ready);
endinterface

// ===== hdl/bfr_parser.sv =====
module bfr_parser #(
    parameter int MAX_DATA = bfr_pkg::MAX_DATA_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    output bfr_pkg::t_result  o_res
);
    import bfr_pkg::*;

    localparam int LW = $clog2(MAX_DATA + 1);
    localparam logic [7:0] MaxCount = 8'(MAX_DATA);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_start_byte;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [LW-1:0] r_left, n_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  count;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_start_byte <= 8'd0;
            r_len        <= 8'd0;
            r_type       <= 8'd0;
            r_left       <= '0;
            r_sum        <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_type  <= n_type;
                r_left  <= n_left;
                r_sum   <= n_sum;
            end
        end
    end

    // data count carried by the length byte
    assign count = (i_rx_byte >= OVERHEAD) ? (i_rx_byte - OVERHEAD) : 8'd0;

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_type      = r_type;
        n_left      = r_left;
        n_sum       = r_sum + i_rx_byte;
        o_res_valid = 1'b0;
        o_res       = '{result_kind: KIND_DATA, data_byte: 8'd0, frame_type: r_type,
                        frame_length: r_len, frame_status: ST_OK};
        case (r_phase)
            PH_LEN: begin
                n_len = i_rx_byte;
                if (count > MaxCount) begin
                    n_phase           = PH_HUNT;
                    o_res_valid       = i_accept;
                    o_res.result_kind = KIND_END;
                    o_res.frame_type  = 8'd0;
                    o_res.frame_length = i_rx_byte;
                    o_res.frame_status = ST_LEN_ERR;
                end else begin
                    n_left  = count[LW-1:0];
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_phase = (r_left != '0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                if (r_left != '0) begin
                    n_left = r_left - LW'(1);
                end
                if (r_left <= LW'(1)) begin
                    n_phase = PH_CHECK;
                end
                o_res_valid     = i_accept;
                o_res.data_byte = i_rx_byte;
            end
            PH_CHECK: begin
                n_phase            = PH_HUNT;
                o_res_valid        = i_accept;
                o_res.result_kind  = KIND_END;
                o_res.frame_status = (i_rx_byte == r_sum) ? ST_OK : ST_SUM_ERR;
            end
            default: begin
                // hunting, also for unused codes
                n_phase = PH_HUNT;
                n_sum   = r_sum;
                if (i_rx_byte == r_start_byte) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_LEN;
                end
            end
        endcase
    end

endmodule

// ===== hdl/bfr_out_buf.sv =====
module bfr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bfr_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    output bfr_pkg::t_result o_res,
    input  logic             i_pop_ready
);
    import bfr_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_pop_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_pop_ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== hdl/byte_frame_receiver_sum_check_top.sv =====
// Length-prefixed byte frame receiver with an 8-bit additive check. One byte
// item is taken per cycle while the output buffer is ready; each result is
// registered there. The rate is set by the parser state update (a compare, an
// 8-bit add and a phase step). Bytes are dropped until one equals the start
// byte register; the following length byte counts four overhead bytes. A data
// count above MAX_DATA gives an end item with length error on the length byte.
// Each data byte is given out as it arrives, and the check byte gives an end
// item with ok or checksum mismatch status. A one-entry skid stage lets input
// continue while a result waits to be taken. Write the start byte only while
// the block is idle.
module byte_frame_receiver_sum_check_top #(
    parameter int MAX_DATA = bfr_pkg::MAX_DATA_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    bfr_in_if.sink     i_in,
    bfr_out_if.source  o_out
);
    import bfr_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    buf_ready;
    t_result out_res;

    assign accept     = i_in.valid && buf_ready;
    assign i_in.ready = buf_ready;

    // frame parser
    bfr_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_in.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register and skid entry
    bfr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_ready     (buf_ready),
        .o_valid     (o_out.valid),
        .o_res       (out_res),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.result_kind  = out_res.result_kind;
    assign o_out.data_byte    = out_res.data_byte;
    assign o_out.frame_type   = out_res.frame_type;
    assign o_out.frame_length = out_res.frame_length;
    assign o_out.frame_status = out_res.frame_status;

endmodule

// ===== test/bfr_frame_checker.sv =====
`timescale 1ns / 1ps

module bfr_frame_checker #(
    parameter int MAX_DATA = bfr_pkg::MAX_DATA_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    bfr_in_if          i_rx_mon,
    bfr_out_if         i_res_mon,
    output int         o_fail_count,
    output int         o_results_due
);
    import bfr_pkg::*;

    // predicted parser state and start byte register
    logic [7:0] start_byte;
    t_phase     parse_phase;
    logic [7:0] held_length;
    logic [7:0] held_type;
    logic [7:0] data_left;
    logic [7:0] frame_sum;

    // result items predicted but not yet seen on the output
    t_result    due_results[$];
    int         mismatches = 0;

    // advance the frame parser by one received byte
    task automatic parse_rx_byte(input logic [7:0] b);
        t_result res;
        int      data_count;
        res = '0;
        case (parse_phase)
            PH_LEN: begin
                held_length = b;
                frame_sum   = frame_sum + b;
                data_count  = (b >= OVERHEAD) ? int'(b - OVERHEAD) : 0;
                if (data_count > MAX_DATA) begin
                    // length error is reported on the length byte, no type read yet
                    parse_phase      = PH_HUNT;
                    res.result_kind  = KIND_END;
                    res.frame_length = b;
                    res.frame_status = ST_LEN_ERR;
                    due_results.push_back(res);
                end else begin
                    data_left   = 8'(data_count);
                    parse_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                held_type   = b;
                frame_sum   = frame_sum + b;
                parse_phase = (data_left != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                frame_sum = frame_sum + b;
                if (data_left != 8'd0) begin
                    data_left = data_left - 8'd1;
                end
                if (data_left == 8'd0) begin
                    parse_phase = PH_CHECK;
                end
                res.result_kind  = KIND_DATA;
                res.data_byte    = b;
                res.frame_type   = held_type;
                res.frame_length = held_length;
                res.frame_status = ST_OK;
                due_results.push_back(res);
            end
            PH_CHECK: begin
                parse_phase      = PH_HUNT;
                res.result_kind  = KIND_END;
                res.frame_type   = held_type;
                res.frame_length = held_length;
                res.frame_status = (b == frame_sum) ? ST_OK : ST_SUM_ERR;
                due_results.push_back(res);
            end
            default: begin
                // hunting: anything but the start byte is dropped
                parse_phase = PH_HUNT;
                if (b == start_byte) begin
                    frame_sum   = b;
                    parse_phase = PH_LEN;
                end
            end
        endcase
    endtask

    // compare one taken result item with the oldest prediction
    task automatic check_result();
        t_result exp;
        if (due_results.size() == 0) begin
            mismatches++;
            $display({"%0t ns: unexpected result item, expected none, ",
                      "got kind %0d data %02h type %02h len %02h status %0d"},
                     $time, i_res_mon.result_kind, i_res_mon.data_byte,
                     i_res_mon.frame_type, i_res_mon.frame_length,
                     i_res_mon.frame_status);
        end else begin
            exp = due_results.pop_front();
            if (i_res_mon.result_kind !== exp.result_kind
                    || i_res_mon.data_byte !== exp.data_byte
                    || i_res_mon.frame_type !== exp.frame_type
                    || i_res_mon.frame_length !== exp.frame_length
                    || i_res_mon.frame_status !== exp.frame_status) begin
                mismatches++;
                $display({"%0t ns: result mismatch, expected kind %0d data %02h ",
                          "type %02h len %02h status %0d"},
                         $time, exp.result_kind, exp.data_byte, exp.frame_type,
                         exp.frame_length, exp.frame_status);
                $display({"%0t ns: result mismatch, actual   kind %0d data %02h ",
                          "type %02h len %02h status %0d"},
                         $time, i_res_mon.result_kind, i_res_mon.data_byte,
                         i_res_mon.frame_type, i_res_mon.frame_length,
                         i_res_mon.frame_status);
            end
        end
    endtask

    // monitor both channels and the register write at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_byte  = 8'd0;
            parse_phase = PH_HUNT;
            held_length = 8'd0;
            held_type   = 8'd0;
            data_left   = 8'd0;
            frame_sum   = 8'd0;
            due_results.delete();
        end else begin
            if (i_rx_mon.valid && i_rx_mon.ready) begin
                parse_rx_byte(i_rx_mon.rx_byte);
            end
            if (i_cfg_we) begin
                start_byte = i_cfg_wdata;
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                check_result();
            end
        end
        o_fail_count  <= mismatches;
        o_results_due <= due_results.size();
    end

endmodule

// ===== test/byte_frame_receiver_sum_check_top_tb.sv =====
`timescale 1ns / 1ps

module byte_frame_receiver_sum_check_top_tb;
    import bfr_pkg::*;

    localparam int MAX_DATA     = MAX_DATA_DEF;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_TICKS = 4;
    localparam int PHASE_ITEMS  = 245;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    int         fail_count;
    int         results_due;

    // idle rates and receiver hold-off requests
    int         src_idle_pct;
    int         sink_idle_pct;
    int         hold_req_cnt;
    int         hold_seen_cnt;
    int         hold_left;

    int         bytes_sent;
    logic [7:0] frame_start;

    bfr_in_if  rx_ch ();
    bfr_out_if res_ch ();

    byte_frame_receiver_sum_check_top #(
        .MAX_DATA (MAX_DATA)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (rx_ch),
        .o_out       (res_ch)
    );

    bfr_frame_checker #(
        .MAX_DATA (MAX_DATA)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_rx_mon      (rx_ch),
        .i_res_mon     (res_ch),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // offer one byte item, idling at random first, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // stop offering and wait until every predicted result item has come
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // write the start byte register; called with no result items outstanding, once in mid-frame
    task automatic set_start_byte(input logic [7:0] v);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        frame_start = v;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    // frame with random type and data, optionally a bad check byte; ends after the length byte if too long
    task automatic send_frame(input logic [7:0] sof, input logic [7:0] len,
                              input bit bad_check);
        logic [7:0] sum;
        logic [7:0] b;
        int         n_data;
        n_data = (len >= OVERHEAD) ? int'(len - OVERHEAD) : 0;
        send_byte(sof);
        send_byte(len);
        if (n_data > MAX_DATA) begin
            return;
        end
        sum = sof + len;
        b = 8'($urandom);
        send_byte(b);
        sum = sum + b;
        repeat (n_data) begin
            b = 8'($urandom);
            send_byte(b);
            sum = sum + b;
        end
        send_byte(bad_check ? (sum ^ 8'($urandom_range(255, 1))) : sum);
    endtask

    // mostly well-formed frames, some noise, length errors and truncated frames
    task automatic run_random_traffic(input int n_items);
        int         goal;
        int         pick;
        logic [7:0] len;
        goal = bytes_sent + n_items;
        while (bytes_sent < goal) begin
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(2, 1)) send_byte(8'($urandom));
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                len = 8'(MAX_DATA + OVERHEAD);
            end else if (pick < 10 && MAX_DATA + OVERHEAD < 255) begin
                len = 8'($urandom_range(255, MAX_DATA + OVERHEAD + 1));
            end else if (pick < 20) begin
                len = 8'($urandom_range(OVERHEAD));
            end else begin
                len = 8'(OVERHEAD + $urandom_range(MAX_DATA < 8 ? MAX_DATA : 8, 1));
            end
            if (pick >= 92) begin
                // truncated frame: the parser swallows what follows
                send_byte(frame_start);
                send_byte(len);
                repeat ($urandom_range(2)) send_byte(8'($urandom));
            end else begin
                send_frame(frame_start, len, $urandom_range(99) < 20);
            end
            if ($urandom_range(11) == 0) begin
                wait_drained();
            end
        end
    endtask

    // receiver: random stalls plus long hold-offs on request
    initial begin
        res_ch.ready <= 1'b0;
        hold_seen_cnt = 0;
        hold_left     = 0;
        forever begin
            @(posedge clk);
            if (hold_req_cnt != hold_seen_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // stimulus and verdict
    initial begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 8'd0;
        hold_req_cnt  <= 0;
        sink_idle_pct <= 0;
        src_idle_pct  = 0;
        bytes_sent    = 0;
        frame_start   = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        set_start_byte(8'h7E);
        send_byte(8'h00);
        send_byte(8'hFF);
        // ok frame with two data bytes at the extremes
        send_byte(8'h7E);
        send_byte(8'h06);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E + 8'h06 + 8'h00 + 8'hFF + 8'h00);
        // short length, no data, wrong check byte
        send_byte(8'h7E);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        // length errors, one past the limit and the largest length
        send_byte(8'h7E);
        send_byte(8'(MAX_DATA + 5));
        send_byte(8'h7E);
        send_byte(8'hFF);
        // length four: no data bytes, good check
        send_byte(8'h7E);
        send_byte(8'h04);
        send_byte(8'h80);
        send_byte(8'h7E + 8'h04 + 8'h80);
        // start byte changed in the middle of a frame
        send_byte(8'h7E);
        send_byte(8'h05);
        wait_drained();
        set_start_byte(8'hFF);
        send_byte(8'h11);
        send_byte(8'hFF);
        send_byte(8'h7E + 8'h05 + 8'h11 + 8'hFF);
        wait_drained();

        // long receiver hold-off against a full-size frame
        hold_req_cnt <= hold_req_cnt + 1;
        send_frame(frame_start, 8'(MAX_DATA + OVERHEAD), 1'b0);
        wait_drained();

        // sender idles lightly, receiver heavily
        set_start_byte(8'h00);
        src_idle_pct  = 19;
        sink_idle_pct <= 74;
        run_random_traffic(PHASE_ITEMS);
        wait_drained();

        // sender idles heavily, receiver lightly
        set_start_byte(8'hFF);
        src_idle_pct  = 74;
        sink_idle_pct <= 19;
        run_random_traffic(PHASE_ITEMS);
        wait_drained();

        // full rate on both sides
        set_start_byte(8'($urandom));
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        run_random_traffic(PHASE_ITEMS);
        wait_drained();

        if (fail_count == 0 && results_due == 0) begin
            $display("[byte_frame_receiver_sum_check_top] OK");
        end else begin
            $display("[byte_frame_receiver_sum_check_top] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("[byte_frame_receiver_sum_check_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bfr_pkg.sv
hdl/bfr_ifs.sv
hdl/bfr_parser.sv
hdl/bfr_out_buf.sv
hdl/byte_frame_receiver_sum_check_top.sv
test/bfr_frame_checker.sv
test/byte_frame_receiver_sum_check_top_tb.sv
